### src/frame_energy_voice_activity_gate_defines.svh
// Assertion macros shared by the voice activity gate RTL.
`ifndef FRAME_ENERGY_VOICE_ACTIVITY_GATE_DEFINES_SVH
`define FRAME_ENERGY_VOICE_ACTIVITY_GATE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define FEVAG_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define FEVAG_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### src/fevag_pkg.sv
// Types, constants and register map of the voice activity gate.
`default_nettype none
package fevag_pkg;

   // Field and state widths
   localparam int SAMPLE_W  = 16;
   localparam int MAG_W     = 16;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUM_W     = 39;
   localparam int LEVEL_W   = 15;
   localparam int LEVEL_SQ_W = 2 * LEVEL_W;
   localparam int CONFIRM_W = 4;
   localparam int LIMIT_W   = 10;
   localparam int LOUD_W    = 4;
   localparam int QUIET_W   = 10;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 4;

   // Default frame length and queue depth
   localparam int MAX_FRAME_DEFAULT = 256;
   localparam int QUEUE_DEPTH       = 4;

   // Register reset values
   localparam logic [LEVEL_W-1:0]   START_LEVEL_RESET    = 15'd200;
   localparam logic [LEVEL_W-1:0]   QUIET_LEVEL_RESET    = 15'd60;
   localparam logic [CONFIRM_W-1:0] CONFIRM_FRAMES_RESET = 4'd2;
   localparam logic [LIMIT_W-1:0]   QUIET_LIMIT_RESET    = 10'd25;

   // Register indexes (byte address / 4)
   typedef enum logic [1:0] {
      CSR_START_LEVEL    = 2'd0,
      CSR_QUIET_LEVEL    = 2'd1,
      CSR_CONFIRM_FRAMES = 2'd2,
      CSR_QUIET_LIMIT    = 2'd3
   } csr_index_type;

   // Gate event codes
   typedef enum logic [1:0] {
      GATE_NONE  = 2'd0,
      GATE_START = 2'd1,
      GATE_END   = 2'd2
   } gate_event_type;

   // Configuration handed from the register file to the decision logic
   typedef struct packed {
      logic [LEVEL_W-1:0]   start_level;
      logic [LEVEL_W-1:0]   quiet_level;
      logic [CONFIRM_W-1:0] confirm_frames;
      logic [LIMIT_W-1:0]   quiet_limit;
   } cfg_type;

endpackage
`default_nettype wire

### src/fevag_csr.sv
// APB-style register file holding the gate thresholds and frame counts.
`default_nettype none
module fevag_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [fevag_pkg::ADDR_W-1:0] paddr,
   input  wire logic [fevag_pkg::DATA_W-1:0] pwdata,
   output logic      [fevag_pkg::DATA_W-1:0] prdata,
   output logic                            pready,
   output fevag_pkg::cfg_type              cfg
);
   import fevag_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index = csr_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;

   // Register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_START_LEVEL:    cfg_in.start_level    = pwdata[LEVEL_W-1:0];
            CSR_QUIET_LEVEL:    cfg_in.quiet_level    = pwdata[LEVEL_W-1:0];
            CSR_CONFIRM_FRAMES: cfg_in.confirm_frames = pwdata[CONFIRM_W-1:0];
            CSR_QUIET_LIMIT:    cfg_in.quiet_limit    = pwdata[LIMIT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_level    <= START_LEVEL_RESET;
         cfg_ff.quiet_level    <= QUIET_LEVEL_RESET;
         cfg_ff.confirm_frames <= CONFIRM_FRAMES_RESET;
         cfg_ff.quiet_limit    <= QUIET_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (index)
         CSR_START_LEVEL:    prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_ff.start_level};
         CSR_QUIET_LEVEL:    prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_ff.quiet_level};
         CSR_CONFIRM_FRAMES: prdata = {{(DATA_W-CONFIRM_W){1'b0}}, cfg_ff.confirm_frames};
         CSR_QUIET_LIMIT:    prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_ff.quiet_limit};
      endcase
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

### src/fevag_front.sv
// Front end: squares each sample and accumulates frame energy and count.
`default_nettype none
module fevag_front #(
   parameter int MAX_FRAME = fevag_pkg::MAX_FRAME_DEFAULT,
   parameter int COUNT_W   = $clog2(MAX_FRAME + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [fevag_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                          req_frame_last,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output logic [fevag_pkg::SUM_W-1:0]        push_sum,
   output logic [COUNT_W-1:0]                 push_count
);
   import fevag_pkg::*;

   localparam logic [COUNT_W-1:0] FrameMax = COUNT_W'(MAX_FRAME);

   logic               a_valid_ff, a_valid_in;
   logic [SQ_W-1:0]    a_sq_ff;
   logic               a_last_ff;
   logic [MAG_W-1:0]   mag;
   logic               accept;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W:0]     sum_add;
   logic [SUM_W-1:0]   sum_sat;
   logic [COUNT_W-1:0] count_inc;
   logic               frame_end;
   logic               a_take;

   // Square stage: magnitude then product
   assign mag    = req_sample[SAMPLE_W-1] ? (~req_sample + 1'b1) : req_sample;
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         a_sq_ff   <= mag * mag;
         a_last_ff <= req_frame_last;
      end
   end

   // Accumulate stage with saturation; frame ends on mark or full count
   assign sum_add   = {1'b0, sum_ff} + {{(SUM_W+1-SQ_W){1'b0}}, a_sq_ff};
   assign sum_sat   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
   assign count_inc = count_ff + 1'b1;
   assign frame_end = a_last_ff || (count_inc == FrameMax);

   assign a_take     = a_valid_ff && (!frame_end || push_ready);
   assign push_valid = a_valid_ff && frame_end;
   assign push_sum   = sum_sat;
   assign push_count = count_inc;
   assign req_ready  = !a_valid_ff || a_take;

   always_comb begin
      a_valid_in = a_valid_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      if (a_take) begin
         a_valid_in = 1'b0;
         if (frame_end) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_sat;
            count_in = count_inc;
         end
      end
      if (accept) begin
         a_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         sum_ff     <= '0;
         count_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
      end
   end
endmodule
`default_nettype wire

### src/fevag_queue.sv
// Short queue of finished frame records between the front and back ends.
`default_nettype none
`include "frame_energy_voice_activity_gate_defines.svh"
module fevag_queue #(
   parameter int WIDTH = 48
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);
   import fevag_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] Depth = CNT_W'(QUEUE_DEPTH);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push, pop;

   assign push_ready = (fill_ff != Depth);
   assign pop_valid  = (fill_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers wrap over the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   `FEVAG_ASSERT(a_fill_bound, clock, reset, fill_ff <= Depth, "queue fill beyond depth")
   `FEVAG_ASSERT(a_fill_track, clock, reset, (push && !pop) |=> (fill_ff == $past(fill_ff) + 1'b1), "queue fill lost a push")
   `FEVAG_ASSERT(a_ptr_gap, clock, reset, (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff), "empty queue with pointer gap")
endmodule
`default_nettype wire

### src/fevag_back.sv
// Back end: level bounds, loud/quiet decision, run counters and result register.
`default_nettype none
`include "frame_energy_voice_activity_gate_defines.svh"
module fevag_back #(
   parameter int MAX_FRAME = fevag_pkg::MAX_FRAME_DEFAULT,
   parameter int COUNT_W   = $clog2(MAX_FRAME + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fevag_pkg::cfg_type     cfg,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire logic [fevag_pkg::SUM_W-1:0] pop_sum,
   input  wire logic [COUNT_W-1:0]     pop_count,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_frame_forwarded,
   output logic [1:0]                  rsp_gate_event,
   output logic                        rsp_recording_now
);
   import fevag_pkg::*;

   localparam int BOUND_W = LEVEL_SQ_W + COUNT_W;
   localparam int CMP_W   = (BOUND_W > SUM_W) ? BOUND_W : SUM_W;

   logic [LEVEL_SQ_W-1:0] start_sq_ff, quiet_sq_ff;
   logic                  s1_valid_ff, s1_valid_in;
   logic [SUM_W-1:0]      s1_sum_ff;
   logic [BOUND_W-1:0]    s1_bstart_ff, s1_bquiet_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_fwd_ff, out_rec_ff;
   gate_event_type        out_event_ff;
   logic                  out_load, pop;
   logic [CMP_W-1:0]      sum_x, bstart_x, bquiet_x;
   logic                  loud, quiet;
   logic [LOUD_W-1:0]     loud_run_ff, loud_run_in, loud_next;
   logic [QUIET_W-1:0]    quiet_run_ff, quiet_run_in, quiet_next;
   logic                  recording_ff, recording_in;
   logic                  fwd;
   gate_event_type        event_code;

   // Level squares follow the registers
   always_ff @(posedge clock) begin
      start_sq_ff <= cfg.start_level * cfg.start_level;
      quiet_sq_ff <= cfg.quiet_level * cfg.quiet_level;
   end

   // Pipeline control
   assign out_load  = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign pop_ready = !s1_valid_ff || out_load;
   assign pop       = pop_valid && pop_ready;

   // Bound stage: level squared times sample count
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_sum_ff    <= pop_sum;
         s1_bstart_ff <= start_sq_ff * pop_count;
         s1_bquiet_ff <= quiet_sq_ff * pop_count;
      end
   end

   // Decision stage
   assign sum_x    = CMP_W'(s1_sum_ff);
   assign bstart_x = CMP_W'(s1_bstart_ff);
   assign bquiet_x = CMP_W'(s1_bquiet_ff);
   assign loud     = sum_x > bstart_x;
   assign quiet    = sum_x < bquiet_x;

   always_comb begin
      loud_run_in  = loud_run_ff;
      quiet_run_in = quiet_run_ff;
      recording_in = recording_ff;
      fwd          = 1'b0;
      event_code   = GATE_NONE;
      loud_next    = loud ? ((&loud_run_ff) ? loud_run_ff : loud_run_ff + 1'b1) : '0;
      quiet_next   = (&quiet_run_ff) ? quiet_run_ff : quiet_run_ff + 1'b1;
      if (!recording_ff) begin
         loud_run_in = loud_next;
         if (loud_next >= cfg.confirm_frames) begin
            recording_in = 1'b1;
            quiet_run_in = '0;
            loud_run_in  = '0;
            event_code   = GATE_START;
         end
      end else begin
         fwd = 1'b1;
         if (quiet) begin
            quiet_run_in = quiet_next;
            if (quiet_next > cfg.quiet_limit) begin
               recording_in = 1'b0;
               quiet_run_in = '0;
               event_code   = GATE_END;
            end
         end else begin
            quiet_run_in = '0;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_fwd_ff   <= fwd;
         out_event_ff <= event_code;
         out_rec_ff   <= recording_in;
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         s1_valid_in = 1'b0;
      end
      if (pop) begin
         s1_valid_in = 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         loud_run_ff  <= '0;
         quiet_run_ff <= '0;
         recording_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (out_load) begin
            loud_run_ff  <= loud_run_in;
            quiet_run_ff <= quiet_run_in;
            recording_ff <= recording_in;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_frame_forwarded = out_fwd_ff;
   assign rsp_gate_event      = out_event_ff;
   assign rsp_recording_now   = out_rec_ff;

   `FEVAG_ASSERT(a_start_flags, clock, reset, (out_valid_ff && out_event_ff == GATE_START) |-> (out_rec_ff && !out_fwd_ff), "start frame flags wrong")
   `FEVAG_ASSERT(a_end_flags, clock, reset, (out_valid_ff && out_event_ff == GATE_END) |-> (!out_rec_ff && out_fwd_ff), "end frame flags wrong")
   `FEVAG_ASSERT(a_rec_tracks, clock, reset, out_load |=> (out_rec_ff == recording_ff), "result flag differs from state")
endmodule
`default_nettype wire

### src/frame_energy_voice_activity_gate.sv
// Top level of the frame-energy voice activity gate.
// Usage:
//   req_* carries one signed 16-bit sample per item with a last-of-frame mark.
//   A frame also closes by itself once it holds MAX_FRAME samples.
//   rsp_* carries one item per closed frame: forwarded flag, gate event
//   (none, recording started, recording ended by silence) and the
//   recording flag after the decision. Samples inside a frame give no item.
//   The APB-style port sets start_level, quiet_level, confirm_frames and
//   quiet_limit at byte addresses 0, 4, 8 and 12; write them while idle.
// Timing:
//   One sample per cycle is taken while the frame queue has room. The
//   result of a frame passes the square register, the accumulator into
//   the frame queue, the bound multiply and the decision into the result
//   register. Rate is set by the single square-and-accumulate stage.
//   If rsp_ready stays low, the result register, the bound stage and a
//   four-entry frame queue absorb six closed frames; once all are full
//   req_ready drops while the next closing sample waits in the square
//   register. Reset is synchronous; it clears all counters and the
//   recording flag and loads the register defaults (200, 60, 2, 25).
`default_nettype none
module frame_energy_voice_activity_gate #(
   parameter int MAX_FRAME = fevag_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [fevag_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                          req_frame_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_frame_forwarded,
   output logic [1:0]                         rsp_gate_event,
   output logic                               rsp_recording_now,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [fevag_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [fevag_pkg::DATA_W-1:0]  pwdata,
   output logic      [fevag_pkg::DATA_W-1:0]  prdata,
   output logic                               pready
);
   import fevag_pkg::*;

   localparam int COUNT_W = $clog2(MAX_FRAME + 1);
   localparam int REC_W   = SUM_W + COUNT_W;

   cfg_type            cfg;
   logic               push_valid, push_ready;
   logic [SUM_W-1:0]   push_sum;
   logic [COUNT_W-1:0] push_count;
   logic               pop_valid, pop_ready;
   logic [REC_W-1:0]   pop_data;

   fevag_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fevag_front #(.MAX_FRAME(MAX_FRAME), .COUNT_W(COUNT_W)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_frame_last (req_frame_last),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_sum       (push_sum),
      .push_count     (push_count)
   );

   fevag_queue #(.WIDTH(REC_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_sum, push_count}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fevag_back #(.MAX_FRAME(MAX_FRAME), .COUNT_W(COUNT_W)) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_sum             (pop_data[REC_W-1:COUNT_W]),
      .pop_count           (pop_data[COUNT_W-1:0]),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_forwarded (rsp_frame_forwarded),
      .rsp_gate_event      (rsp_gate_event),
      .rsp_recording_now   (rsp_recording_now)
   );
endmodule
`default_nettype wire
